[hw/rtl/tsq_pkg.sv]
// Shared types and constants of the touch sample qualifier.
package tsq_pkg;

  // ADC sample width, fixed by the sample field
  localparam int SAMPLE_BITS = 12;
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = '1;

  // Configuration port widths
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  // Coordinate and calibration widths
  localparam int COORD_W = 16;
  localparam int GAIN_W  = 16;
  localparam int FRAC_W  = 14;
  localparam int PROD_W  = GAIN_W + SAMPLE_BITS + 1;
  localparam logic [COORD_W-1:0] COORD_IDLE = '1;

  // Reset values of the configuration registers
  localparam logic signed [GAIN_W-1:0]   GAIN_RESET  = 16'sd16384;
  localparam logic [SAMPLE_BITS-1:0]     AGREE_RESET = 12'd50;

  // Input operation codes
  typedef enum logic [1:0] {
    OP_SAMPLE,
    OP_PENUP,
    OP_ACK
  } tsq_op_t;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_RAW_MODE,
    REG_X_GAIN,
    REG_X_OFFSET,
    REG_Y_GAIN,
    REG_Y_OFFSET,
    REG_AGREE_RANGE
  } tsq_reg_t;

  // Command kinds passed from front to back
  typedef enum logic [1:0] {
    CMD_MEAN,
    CMD_PENUP,
    CMD_ACK
  } tsq_kind_t;

  typedef struct packed {
    logic [1:0]             operation;
    logic [SAMPLE_BITS-1:0] sample;
  } tsq_in_t;

  typedef struct packed {
    logic [COORD_W-1:0] x_position;
    logic [COORD_W-1:0] y_position;
    logic [COORD_W-1:0] first_x;
    logic [COORD_W-1:0] first_y;
    logic               pressed;
    logic               caught;
    logic               agreed;
  } tsq_result_t;

  typedef struct packed {
    tsq_kind_t              kind;
    logic [1:0]             grp;
    logic [SAMPLE_BITS-1:0] mean;
  } tsq_cmd_t;

endpackage

[hw/rtl/tsq_fifo.sv]
// Small register queue with occupancy count.
module tsq_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           push_data,
  input  logic                       pop,
  output logic [WIDTH-1:0]           pop_data,
  output logic                       empty,
  output logic                       full,
  output logic [$clog2(DEPTH+1)-1:0] count
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic             do_push;
  logic             do_pop;

  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign empty    = (count == '0);
  assign full     = (count == CNT_W'(DEPTH));
  assign pop_data = mem[rd_ptr];

  // Store the pushed word
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end
endmodule

[hw/rtl/tsq_front.sv]
// Front end: sample grouping, trimmed sum and constant division.
module tsq_front #(
  parameter int SAMPLES_PER_READ = 5
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  tsq_pkg::tsq_in_t  item,
  output logic              cmd_valid,
  output tsq_pkg::tsq_cmd_t cmd,
  output logic [1:0]        inflight
);
  import tsq_pkg::*;

  localparam int DIV    = SAMPLES_PER_READ - 2;
  localparam int SUM_W  = $clog2(SAMPLES_PER_READ * (2**SAMPLE_BITS - 1) + 1);
  localparam int TRIM_W = $clog2(DIV * (2**SAMPLE_BITS - 1) + 1);
  localparam int SHIFT  = TRIM_W + $clog2(DIV);
  localparam int RW     = SHIFT + 1;
  localparam int PW     = TRIM_W + RW;
  localparam int CNT_W  = $clog2(SAMPLES_PER_READ);
  localparam logic [63:0] ONE_SHIFTED = 64'd1 << SHIFT;
  localparam logic [RW-1:0] RECIP = RW'((ONE_SHIFTED + 64'(DIV) - 64'd1) / 64'(DIV));

  logic [CNT_W-1:0]       cnt, cnt_next;
  logic [1:0]             grp, grp_next;
  logic [SUM_W-1:0]       group_sum, group_sum_next;
  logic [SAMPLE_BITS-1:0] group_min, group_min_next;
  logic [SAMPLE_BITS-1:0] group_max, group_max_next;

  logic                   s1_valid, s1_valid_next;
  tsq_kind_t              s1_kind, s1_kind_next;
  logic [1:0]             s1_grp, s1_grp_next;
  logic [TRIM_W-1:0]      s1_trim, s1_trim_next;

  logic [SAMPLE_BITS-1:0] s;
  logic [SUM_W-1:0]       sum_add, trim_full;
  logic [SAMPLE_BITS-1:0] min_upd, max_upd;
  logic [PW-1:0]          product;

  // Group arithmetic on the incoming sample
  always_comb begin
    s         = item.sample[SAMPLE_BITS-1:0];
    sum_add   = group_sum + SUM_W'(s);
    min_upd   = (s < group_min) ? s : group_min;
    max_upd   = (s > group_max) ? s : group_max;
    trim_full = sum_add - SUM_W'(min_upd) - SUM_W'(max_upd);
  end

  // Classify the accepted word
  always_comb begin
    cnt_next       = cnt;
    grp_next       = grp;
    group_sum_next = group_sum;
    group_min_next = group_min;
    group_max_next = group_max;
    s1_valid_next  = 1'b0;
    s1_kind_next   = CMD_ACK;
    s1_grp_next    = grp;
    s1_trim_next   = trim_full[TRIM_W-1:0];
    if (accept) begin
      case (item.operation)
        OP_SAMPLE: begin
          if (cnt == CNT_W'(SAMPLES_PER_READ - 1)) begin
            // group done: emit trimmed sum, clear group
            s1_valid_next  = 1'b1;
            s1_kind_next   = CMD_MEAN;
            cnt_next       = '0;
            grp_next       = grp + 1'b1;
            group_sum_next = '0;
            group_min_next = SAMPLE_MAX;
            group_max_next = '0;
          end else begin
            cnt_next       = cnt + 1'b1;
            group_sum_next = sum_add;
            group_min_next = min_upd;
            group_max_next = max_upd;
          end
        end
        OP_PENUP: begin
          // drop any partial scan
          s1_valid_next  = 1'b1;
          s1_kind_next   = CMD_PENUP;
          cnt_next       = '0;
          grp_next       = '0;
          group_sum_next = '0;
          group_min_next = SAMPLE_MAX;
          group_max_next = '0;
        end
        OP_ACK: begin
          s1_valid_next = 1'b1;
          s1_kind_next  = CMD_ACK;
        end
        default: begin
          s1_valid_next = 1'b0;
        end
      endcase
    end
  end

  // Group state and valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      grp       <= '0;
      group_sum <= '0;
      group_min <= SAMPLE_MAX;
      group_max <= '0;
      s1_valid  <= 1'b0;
      cmd_valid <= 1'b0;
    end else begin
      cnt       <= cnt_next;
      grp       <= grp_next;
      group_sum <= group_sum_next;
      group_min <= group_min_next;
      group_max <= group_max_next;
      s1_valid  <= s1_valid_next;
      cmd_valid <= s1_valid;
    end
  end

  // Divide the trimmed sum by reciprocal multiplication
  assign product = PW'(s1_trim) * PW'(RECIP);

  // Stage payloads
  always_ff @(posedge clk) begin
    s1_kind  <= s1_kind_next;
    s1_grp   <= s1_grp_next;
    s1_trim  <= s1_trim_next;
    cmd.kind <= s1_kind;
    cmd.grp  <= s1_grp;
    cmd.mean <= product[SHIFT +: SAMPLE_BITS];
  end

  assign inflight = {1'b0, s1_valid} + {1'b0, cmd_valid};
endmodule

[hw/rtl/tsq_back.sv]
// Back end: scan qualification, calibration and pen state.
module tsq_back (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  input  logic [tsq_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tsq_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            cmd_empty,
  input  tsq_pkg::tsq_cmd_t               cmd,
  output logic                            cmd_pop,
  input  logic                            out_full,
  output logic                            res_push,
  output tsq_pkg::tsq_result_t            res
);
  import tsq_pkg::*;

  // Configuration registers
  logic                          raw_mode;
  logic signed [GAIN_W-1:0]      x_gain, x_offset, y_gain, y_offset;
  logic [SAMPLE_BITS-1:0]        agree_range;

  // Readings of the current scan
  logic [SAMPLE_BITS-1:0]        first_read_x, first_read_y, second_read_x;

  // Stage A
  logic                          a_valid;
  tsq_kind_t                     a_kind;
  logic                          a_ok;
  logic [SAMPLE_BITS-1:0]        a_ax, a_ay;
  logic signed [PROD_W-1:0]      a_px, a_py;

  // Pen state
  logic [COORD_W-1:0]            current_x, current_x_next;
  logic [COORD_W-1:0]            current_y, current_y_next;
  logic [COORD_W-1:0]            press_x, press_x_next;
  logic [COORD_W-1:0]            press_y, press_y_next;
  logic                          pen_held, pen_held_next;
  logic                          press_caught, press_caught_next;

  logic                          en;
  logic                          scan_end;
  logic [SAMPLE_BITS-1:0]        diff_x, diff_y;
  logic                          ok;
  logic [SAMPLE_BITS:0]          sum_x, sum_y;
  logic [SAMPLE_BITS-1:0]        ax, ay;
  logic signed [PROD_W-1:0]      px, py;
  logic [COORD_W-1:0]            cal_x, cal_y;

  // Offset add, truncate toward zero, clamp to the screen range
  function automatic logic [COORD_W-1:0] calibrate(
    input logic signed [PROD_W-1:0] prod,
    input logic signed [GAIN_W-1:0] off
  );
    logic signed [PROD_W+1:0] p;
    p = (PROD_W+2)'(prod) + ((PROD_W+2)'(off) <<< FRAC_W);
    // nonnegative sums stay below 2^30, so the quotient fits 16 bits
    if (p[PROD_W+1]) begin
      return '0;
    end
    return p[FRAC_W +: COORD_W];
  endfunction

  assign en      = !out_full;
  assign cmd_pop = en && !cmd_empty;
  assign scan_end = (cmd.kind == CMD_MEAN) && (cmd.grp == 2'd3);

  // Compare and average the two readings of each axis
  always_comb begin
    diff_x = (first_read_x > second_read_x) ? first_read_x - second_read_x
                                            : second_read_x - first_read_x;
    diff_y = (first_read_y > cmd.mean) ? first_read_y - cmd.mean
                                       : cmd.mean - first_read_y;
    ok     = (diff_x < agree_range) && (diff_y < agree_range);
    sum_x  = {1'b0, first_read_x} + {1'b0, second_read_x};
    sum_y  = {1'b0, first_read_y} + {1'b0, cmd.mean};
    ax     = sum_x[SAMPLE_BITS:1];
    ay     = sum_y[SAMPLE_BITS:1];
    px     = x_gain * $signed({1'b0, ax});
    py     = y_gain * $signed({1'b0, ay});
  end

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      raw_mode    <= 1'b0;
      x_gain      <= GAIN_RESET;
      x_offset    <= '0;
      y_gain      <= GAIN_RESET;
      y_offset    <= '0;
      agree_range <= AGREE_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_RAW_MODE:    raw_mode    <= cfg_data[0];
        REG_X_GAIN:      x_gain      <= cfg_data;
        REG_X_OFFSET:    x_offset    <= cfg_data;
        REG_Y_GAIN:      y_gain      <= cfg_data;
        REG_Y_OFFSET:    y_offset    <= cfg_data;
        REG_AGREE_RANGE: agree_range <= cfg_data[SAMPLE_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // Stage A: latch group means, launch scan ends and pen commands
  always_ff @(posedge clk) begin
    if (rst) begin
      first_read_x  <= '0;
      first_read_y  <= '0;
      second_read_x <= '0;
      a_valid       <= 1'b0;
    end else if (en) begin
      a_valid <= cmd_pop && ((cmd.kind != CMD_MEAN) || scan_end);
      if (cmd_pop && (cmd.kind == CMD_MEAN)) begin
        case (cmd.grp)
          2'd0:    first_read_x  <= cmd.mean;
          2'd1:    first_read_y  <= cmd.mean;
          2'd2:    second_read_x <= cmd.mean;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_kind <= cmd.kind;
      a_ok   <= ok;
      a_ax   <= ax;
      a_ay   <= ay;
      a_px   <= px;
      a_py   <= py;
    end
  end

  assign cal_x = calibrate(a_px, x_offset);
  assign cal_y = calibrate(a_py, y_offset);

  // Stage B: update coordinates and pen state, build the result word
  always_comb begin
    current_x_next    = current_x;
    current_y_next    = current_y;
    press_x_next      = press_x;
    press_y_next      = press_y;
    pen_held_next     = pen_held;
    press_caught_next = press_caught;
    res_push          = 1'b0;
    res.agreed        = 1'b0;
    if (en && a_valid) begin
      case (a_kind)
        CMD_MEAN: begin
          if (a_ok) begin
            current_x_next = raw_mode ? COORD_W'(a_ax) : cal_x;
            current_y_next = raw_mode ? COORD_W'(a_ay) : cal_y;
          end
          if (!pen_held) begin
            pen_held_next     = 1'b1;
            press_caught_next = 1'b1;
            press_x_next      = current_x_next;
            press_y_next      = current_y_next;
          end
          res_push   = 1'b1;
          res.agreed = a_ok;
        end
        CMD_PENUP: begin
          if (pen_held) begin
            pen_held_next = 1'b0;
          end else begin
            press_x_next   = '0;
            press_y_next   = '0;
            current_x_next = COORD_IDLE;
            current_y_next = COORD_IDLE;
          end
          res_push = 1'b1;
        end
        CMD_ACK: begin
          press_caught_next = 1'b0;
        end
        default: begin
        end
      endcase
    end
    res.x_position = current_x_next;
    res.y_position = current_y_next;
    res.first_x    = press_x_next;
    res.first_y    = press_y_next;
    res.pressed    = pen_held_next;
    res.caught     = press_caught_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_x    <= '0;
      current_y    <= '0;
      press_x      <= '0;
      press_y      <= '0;
      pen_held     <= 1'b0;
      press_caught <= 1'b0;
    end else begin
      current_x    <= current_x_next;
      current_y    <= current_y_next;
      press_x      <= press_x_next;
      press_y      <= press_y_next;
      pen_held     <= pen_held_next;
      press_caught <= press_caught_next;
    end
  end
endmodule

[hw/rtl/touch_sample_qualifier_unit.sv]
// A scan's last sample passes the front s1 and cmd registers, the command queue and back
// stages A and B into the result queue. Throughput: one input word per cycle while queue
// credits keep full low; the front divider and the two back stages are fully pipelined.
// Reset (rst, synchronous): clears the group, the scan readings, the pen state and
// both queues, and restores the register defaults; no clearing pass follows.
module touch_sample_qualifier_unit #(
  parameter int SAMPLES_PER_READ = 5,
  parameter int MID_DEPTH        = 4,
  parameter int OUT_DEPTH        = 2
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  tsq_pkg::tsq_in_t                item,
  output logic                            empty,
  input  logic                            pop,
  output tsq_pkg::tsq_result_t            result,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tsq_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tsq_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import tsq_pkg::*;

  localparam int MID_CW = $clog2(MID_DEPTH+1);
  localparam int OUT_CW = $clog2(OUT_DEPTH+1);

  logic                 accept;
  logic                 cmd_valid;
  tsq_cmd_t             cmd_in, cmd_out;
  logic [1:0]           inflight;
  logic [MID_CW-1:0]    mid_count;
  logic [MID_CW:0]      credit_used;
  logic                 mid_empty, mid_full;
  logic                 cmd_pop;
  logic                 out_full;
  logic [OUT_CW-1:0]    out_count;
  logic                 res_push;
  tsq_result_t          res;

  assign cfg_ready = 1'b1;
  assign accept    = push && !full;

  // Hold input while queued plus in-flight commands could fill the queue
  assign credit_used = (MID_CW+1)'(mid_count) + (MID_CW+1)'(inflight);
  assign full        = (credit_used >= (MID_CW+1)'(MID_DEPTH));

  tsq_front #(
    .SAMPLES_PER_READ(SAMPLES_PER_READ)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .item     (item),
    .cmd_valid(cmd_valid),
    .cmd      (cmd_in),
    .inflight (inflight)
  );

  tsq_fifo #(
    .WIDTH($bits(tsq_cmd_t)),
    .DEPTH(MID_DEPTH)
  ) u_cmd_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (cmd_valid),
    .push_data(cmd_in),
    .pop      (cmd_pop),
    .pop_data (cmd_out),
    .empty    (mid_empty),
    .full     (mid_full),
    .count    (mid_count)
  );

  tsq_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cmd_empty(mid_empty),
    .cmd      (cmd_out),
    .cmd_pop  (cmd_pop),
    .out_full (out_full),
    .res_push (res_push),
    .res      (res)
  );

  tsq_fifo #(
    .WIDTH($bits(tsq_result_t)),
    .DEPTH(OUT_DEPTH)
  ) u_out_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (res_push),
    .push_data(res),
    .pop      (pop),
    .pop_data (result),
    .empty    (empty),
    .full     (out_full),
    .count    (out_count)
  );

  // Command credits never exceed the queue depth
  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    credit_used <= (MID_CW+1)'(MID_DEPTH))
    else $error("command credits overrun");

  // A command leaving the divider always finds room
  a_cmd_room: assert property (@(posedge clk) disable iff (rst)
    cmd_valid |-> !mid_full)
    else $error("command pushed into full queue");

  // The back end only produces a word when the result queue has room
  a_res_room: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !out_full)
    else $error("result pushed into full queue");

  // The result queue never holds more words than its depth
  a_out_bound: assert property (@(posedge clk) disable iff (rst)
    out_count <= OUT_CW'(OUT_DEPTH))
    else $error("result queue overrun");
endmodule
